FILE: rtl/trs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_pkg: shared types and constants of the triple rank order score block
// Item formats, configuration register indexes and the fixed sizes of the
// score path and of the snapshot queue.
// ----------------------------------------------------------------------------
package trs_pkg;

  // field widths fixed by the item formats
  localparam int GENE_W     = 16;
  localparam int EXPR_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int SCORE_W    = 18;
  localparam int FRAC_SHIFT = 17;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 18'd131072;

  // six orderings of a triple
  localparam int ORDER_COUNT = 6;
  localparam int BIN_W       = 3;

  // snapshot queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GENE_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENE_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GENE_C = 2'd2;

  typedef struct packed {
    logic [GENE_W-1:0]        gene_index;
    logic signed [EXPR_W-1:0] expr_value;
    logic                     class_label;
    logic                     end_of_sample;
    logic                     end_of_set;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               empty_class;
  } out_item_t;

  // snapshot queue status seen by front and back
  typedef struct packed {
    logic              nonempty;
    logic [QCNT_W-1:0] count;
  } snapq_stat_t;

endpackage

FILE: rtl/trs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_front: item intake and per-set ordering counts
// Holds the three gene values, classifies each closed sample into the six
// ordering bins and accumulates per-class credits. At set end it pushes a
// snapshot of the counts to the snapshot queue and clears them.
// ----------------------------------------------------------------------------
module trs_front #(
  parameter int MAX_SAMPLES = 4096,
  parameter int MAX_GENES   = 65536,
  parameter int VALUE_WIDTH = 32,
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W = $clog2(6 * MAX_SAMPLES + 1)
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_push,
  output logic                                            in_full,
  input  trs_pkg::in_item_t                               in_item,
  input  logic                                            cfg_valid,
  output logic                                            cfg_ready,
  input  logic [trs_pkg::CFG_IDX_W-1:0]                   cfg_index,
  input  logic [trs_pkg::GENE_W-1:0]                      cfg_data,
  input  trs_pkg::snapq_stat_t                            q_stat,
  output logic                                            q_push,
  output logic [1:0][trs_pkg::ORDER_COUNT-1:0][SUM_W-1:0] q_sums,
  output logic [1:0][CNT_W-1:0]                           q_totals
);
  import trs_pkg::*;

  // credit per holding ordering, in sixths
  localparam logic [2:0] W_DISTINCT = 3'd6;
  localparam logic [2:0] W_PAIR     = 3'd3;
  localparam logic [2:0] W_ALL_EQ   = 3'd1;

  logic [GENE_W-1:0]             gene_a_r, gene_b_r, gene_c_r;
  logic signed [VALUE_WIDTH-1:0] held_a_r, held_b_r, held_c_r;
  logic signed [VALUE_WIDTH-1:0] in_val;
  logic                          in_accept;
  logic                          gene_ok;
  logic                          s2_close_r, s2_set_r, s2_cls_r;
  logic                          s3_close_r, s3_set_r, s3_cls_r;
  logic                          le_ab, le_ba, le_ac, le_ca, le_bc, le_cb;
  logic [ORDER_COUNT-1:0]        hold, s3_hold_r;
  logic [2:0]                    weight, s3_weight_r;
  logic [1:0][ORDER_COUNT-1:0][SUM_W-1:0] sums_r, sums_nxt;
  logic [1:0][CNT_W-1:0]         totals_r, totals_nxt;
  logic [CNT_W-1:0]              total_r, total_nxt;
  logic [QCNT_W:0]               reserved;

  assign cfg_ready = 1'b1;

  // queue slots taken or promised to set ends still in the pipeline
  assign reserved = {1'b0, q_stat.count} + (QCNT_W+1)'(s2_set_r)
                  + (QCNT_W+1)'(s3_set_r);
  assign in_full   = reserved >= (QCNT_W+1)'(QDEPTH);
  assign in_accept = in_push && !in_full;

  assign in_val  = VALUE_WIDTH'(in_item.expr_value);
  assign gene_ok = int'(in_item.gene_index) < MAX_GENES;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gene_a_r <= GENE_W'(0);
      gene_b_r <= GENE_W'(1);
      gene_c_r <= GENE_W'(2);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GENE_A: gene_a_r <= cfg_data;
        CFG_GENE_B: gene_b_r <= cfg_data;
        CFG_GENE_C: gene_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // held gene values, kept across samples and sets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_a_r <= '0;
      held_b_r <= '0;
      held_c_r <= '0;
    end else if (in_accept && gene_ok) begin
      if (in_item.gene_index == gene_a_r) held_a_r <= in_val;
      if (in_item.gene_index == gene_b_r) held_b_r <= in_val;
      if (in_item.gene_index == gene_c_r) held_c_r <= in_val;
    end
  end

  // stage 2: sample close marker, held values are current in this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_close_r <= 1'b0;
      s2_set_r   <= 1'b0;
      s2_cls_r   <= 1'b0;
    end else begin
      s2_close_r <= in_accept && (in_item.end_of_sample || in_item.end_of_set);
      s2_set_r   <= in_accept && in_item.end_of_set;
      s2_cls_r   <= in_item.class_label;
    end
  end

  // pairwise order of the held values
  assign le_ab = held_a_r <= held_b_r;
  assign le_ba = held_b_r <= held_a_r;
  assign le_ac = held_a_r <= held_c_r;
  assign le_ca = held_c_r <= held_a_r;
  assign le_bc = held_b_r <= held_c_r;
  assign le_cb = held_c_r <= held_b_r;

  assign hold[0] = le_ab && le_bc;
  assign hold[1] = le_ac && le_cb;
  assign hold[2] = le_ba && le_ac;
  assign hold[3] = le_bc && le_ca;
  assign hold[4] = le_ca && le_ab;
  assign hold[5] = le_cb && le_ba;

  // share six sixths among the orderings that hold
  always_comb begin
    case ($countones(hold))
      1:       weight = W_DISTINCT;
      2:       weight = W_PAIR;
      default: weight = W_ALL_EQ;
    endcase
  end

  // stage 3 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_close_r  <= 1'b0;
      s3_set_r    <= 1'b0;
      s3_cls_r    <= 1'b0;
      s3_hold_r   <= '0;
      s3_weight_r <= '0;
    end else begin
      s3_close_r  <= s2_close_r;
      s3_set_r    <= s2_set_r;
      s3_cls_r    <= s2_cls_r;
      s3_hold_r   <= hold;
      s3_weight_r <= weight;
    end
  end

  // credit accumulation, samples past the limit are dropped
  always_comb begin
    sums_nxt   = sums_r;
    totals_nxt = totals_r;
    total_nxt  = total_r;
    if (s3_close_r && (total_r < CNT_W'(MAX_SAMPLES))) begin
      for (int i = 0; i < ORDER_COUNT; i++) begin
        if (s3_hold_r[i]) begin
          sums_nxt[s3_cls_r][i] = sums_r[s3_cls_r][i] + SUM_W'(s3_weight_r);
        end
      end
      totals_nxt[s3_cls_r] = totals_r[s3_cls_r] + CNT_W'(1);
      total_nxt            = total_r + CNT_W'(1);
    end
  end

  assign q_push   = s3_set_r;
  assign q_sums   = sums_nxt;
  assign q_totals = totals_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      sums_r   <= '0;
      totals_r <= '0;
      total_r  <= '0;
    end else begin
      sums_r   <= sums_nxt;
      totals_r <= totals_nxt;
      total_r  <= total_nxt;
    end
  end

endmodule

FILE: rtl/trs_snapq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_snapq: snapshot queue between front and back
// Two-entry queue of per-set counts. The front only pushes into a slot it
// has reserved, so a push is always taken.
// ----------------------------------------------------------------------------
module trs_snapq #(
  parameter int MAX_SAMPLES = 4096,
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W = $clog2(6 * MAX_SAMPLES + 1)
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            push,
  input  logic [1:0][trs_pkg::ORDER_COUNT-1:0][SUM_W-1:0] push_sums,
  input  logic [1:0][CNT_W-1:0]                           push_totals,
  input  logic                                            pop,
  output logic [1:0][trs_pkg::ORDER_COUNT-1:0][SUM_W-1:0] head_sums,
  output logic [1:0][CNT_W-1:0]                           head_totals,
  output trs_pkg::snapq_stat_t                            stat
);
  import trs_pkg::*;

  logic [1:0][ORDER_COUNT-1:0][SUM_W-1:0] sums_mem_r [QDEPTH];
  logic [1:0][CNT_W-1:0]                  tot_mem_r  [QDEPTH];
  logic [QPTR_W-1:0]                      wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]                      cnt_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (!push && pop) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      sums_mem_r[wr_ptr_r] <= push_sums;
      tot_mem_r[wr_ptr_r]  <= push_totals;
    end
  end

  assign head_sums     = sums_mem_r[rd_ptr_r];
  assign head_totals   = tot_mem_r[rd_ptr_r];
  assign stat.nonempty = cnt_r != '0;
  assign stat.count    = cnt_r;

endmodule

FILE: rtl/trs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_back: score engine and result register
// Per set: six cross products and absolute differences, the denominator
// 6*n0*n1, then an 18-step restoring division for the rounded Q2.16 score.
// ----------------------------------------------------------------------------
module trs_back #(
  parameter int MAX_SAMPLES = 4096,
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int SUM_W = $clog2(6 * MAX_SAMPLES + 1)
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  trs_pkg::snapq_stat_t                            q_stat,
  input  logic [1:0][trs_pkg::ORDER_COUNT-1:0][SUM_W-1:0] head_sums,
  input  logic [1:0][CNT_W-1:0]                           head_totals,
  output logic                                            q_pop,
  input  logic                                            out_pop,
  output logic                                            out_empty,
  output trs_pkg::out_item_t                              out_item
);
  import trs_pkg::*;

  localparam int PROD_W = SUM_W + CNT_W;
  localparam int NUM_W  = PROD_W + 3;
  localparam int P_W    = 2 * CNT_W;
  localparam int DEN_W  = P_W + 3;
  localparam int DIV_W  = DEN_W + 1;
  localparam int X_W    = NUM_W + FRAC_SHIFT + 1;
  localparam int IT_W   = $clog2(SCORE_W);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_ACC  = 7'b0000100,
    ST_DEN  = 7'b0001000,
    ST_PREP = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [BIN_W-1:0]   bin_r;
  logic [PROD_W-1:0]  x_r, y_r, prod_x, prod_y, diff;
  logic [NUM_W-1:0]   num_r;
  logic [P_W-1:0]     p_r;
  logic [DEN_W-1:0]   den;
  logic [X_W-1:0]     x_full;
  logic [DIV_W-1:0]   d_r, rem_r;
  logic [DIV_W:0]     rs, rs_sub;
  logic               rs_ge;
  logic [SCORE_W-1:0] xl_r, q_r, score_sat;
  logic [IT_W-1:0]    it_r;
  logic               empty_r;
  logic [CNT_W-1:0]   n0, n1;
  logic               emit_load;
  logic               out_valid_r;
  out_item_t          out_item_r;

  assign n0 = head_totals[0];
  assign n1 = head_totals[1];

  // cross products of the current bin
  assign prod_x = PROD_W'(head_sums[0][bin_r]) * PROD_W'(n1);
  assign prod_y = PROD_W'(head_sums[1][bin_r]) * PROD_W'(n0);
  assign diff   = (x_r >= y_r) ? (x_r - y_r) : (y_r - x_r);

  // rounded dividend num*2^17 + den over divisor 2*den
  assign den    = (DEN_W'(p_r) << 2) + (DEN_W'(p_r) << 1);
  assign x_full = X_W'({num_r, {FRAC_SHIFT{1'b0}}}) + X_W'(den);

  // one restoring division step
  assign rs     = {rem_r, xl_r[SCORE_W-1]};
  assign rs_ge  = rs >= {1'b0, d_r};
  assign rs_sub = rs - {1'b0, d_r};

  assign score_sat = (q_r > SCORE_MAX) ? SCORE_MAX : q_r;
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_pop);
  assign q_pop     = emit_load;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_stat.nonempty) begin
          state_nxt = (n0 == '0 || n1 == '0) ? ST_EMIT : ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = (bin_r == BIN_W'(ORDER_COUNT - 1)) ? ST_DEN : ST_MUL;
      end
      ST_DEN:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (it_r == IT_W'(SCORE_W - 1)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        bin_r   <= '0;
        num_r   <= '0;
        q_r     <= '0;
        empty_r <= (n0 == '0 || n1 == '0);
      end
      ST_MUL: begin
        x_r <= prod_x;
        y_r <= prod_y;
      end
      ST_ACC: begin
        num_r <= num_r + NUM_W'(diff);
        bin_r <= bin_r + BIN_W'(1);
      end
      ST_DEN: begin
        p_r <= P_W'(n0) * P_W'(n1);
      end
      ST_PREP: begin
        d_r   <= DIV_W'({den, 1'b0});
        rem_r <= DIV_W'(x_full >> SCORE_W);
        xl_r  <= x_full[SCORE_W-1:0];
        q_r   <= '0;
        it_r  <= '0;
      end
      ST_DIV: begin
        rem_r <= rs_ge ? DIV_W'(rs_sub) : DIV_W'(rs);
        xl_r  <= {xl_r[SCORE_W-2:0], 1'b0};
        q_r   <= {q_r[SCORE_W-2:0], rs_ge};
        it_r  <= it_r + IT_W'(1);
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_item_r.score       <= empty_r ? '0 : score_sat;
      out_item_r.empty_class <= empty_r;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/triple_rank_order_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triple_rank_order_score: streaming rank-order score of a gene triple
// Scores how well the ordering of three configured genes separates two
// sample classes over a streamed expression matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (in_push / in_full): one matrix element per item, taken at
//   one item per clock while in_full is low. end_of_sample closes a sample,
//   end_of_set closes the sample and the set and yields one result.
//   Result queue (out_empty / out_pop): one score item per set, held on
//   out_item until popped.
//   Config (cfg_valid / cfg_ready): gene_a, gene_b, gene_c at indexes 0..2,
//   always ready, used from the next element on.
//   Back end per set: the six cross products, then the denominator, then
//   the bit-serial divider; a set with an empty class skips straight to
//   its result.
//   Throughput: one element per cycle while in_full is low; short sets
//   are paced by the score engine through the two-entry snapshot queue.
//   in_full rises while two finished sets wait or are in flight.
//   Reset: synchronous, clears counts, held values and both queues; gene
//   registers return to 0, 1, 2. A stalled receiver holds the result and,
//   once the snapshot queue fills, stalls the input.
// ----------------------------------------------------------------------------
module triple_rank_order_score #(
  parameter int MAX_SAMPLES = 4096,
  parameter int MAX_GENES   = 65536,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  trs_pkg::in_item_t              in_item,
  output logic                           out_empty,
  input  logic                           out_pop,
  output trs_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [trs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trs_pkg::GENE_W-1:0]     cfg_data
);
  import trs_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = $clog2(6 * MAX_SAMPLES + 1);

  logic                                   q_push, q_pop;
  logic [1:0][ORDER_COUNT-1:0][SUM_W-1:0] q_sums, head_sums;
  logic [1:0][CNT_W-1:0]                  q_totals, head_totals;
  snapq_stat_t                            q_stat;

  // intake and per-set counting
  trs_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_GENES   (MAX_GENES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_sums    (q_sums),
    .q_totals  (q_totals)
  );

  // per-set snapshots
  trs_snapq #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_snapq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (q_push),
    .push_sums   (q_sums),
    .push_totals (q_totals),
    .pop         (q_pop),
    .head_sums   (head_sums),
    .head_totals (head_totals),
    .stat        (q_stat)
  );

  // score computation and result
  trs_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .head_sums   (head_sums),
    .head_totals (head_totals),
    .q_pop       (q_pop),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_item    (out_item)
  );

endmodule

FILE: rtl/trs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_checker: port-level checks of the triple rank order score block
// Watches the result queue and the input full flag over time.
// ----------------------------------------------------------------------------
module trs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input trs_pkg::out_item_t out_item
);
  import trs_pkg::*;

  // reset leaves both queues open and empty
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not clear after reset");

  // a waiting result stays until popped
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("result item changed while waiting");

  // empty class carries a zero score
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.empty_class |-> out_item.score == '0)
    else $error("nonzero score with empty class");

  // score never above 2.0
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.score <= SCORE_MAX)
    else $error("score above 2.0");

endmodule

bind triple_rank_order_score trs_checker u_trs_checker (.*);

FILE: tb/sv/triple_rank_order_score_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triple_rank_order_score_tb: self-checking bench for the triple rank score
// A table of hand-built matrix elements is walked first: reset state, value
// extremes, ties, an empty class and a set closed without end of sample.
// Random data sets follow under several gene selections, including repeated
// genes and wide gene indexes. A local score model, or a typed table row,
// predicts every result, which is compared in order against the result
// queue. Both sides idle in short random bursts, and once the result side
// holds off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module triple_rank_order_score_tb;
  import trs_pkg::*;

  localparam int MAX_SAMPLES  = 4096;
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD    = 400;
  localparam int TIMEOUT_NS   = 3_000_000;

  // register index the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int { VAL_NARROW, VAL_WIDE, VAL_EDGE } val_mode_t;
  typedef enum int { PH_RANDOM, PH_CLOSING } phase_kind_t;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } table_row_t;

  // DUT connections
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_push   = 1'b0;
  logic        in_full;
  in_item_t    in_item   = '0;
  logic        out_empty;
  logic        out_pop   = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GENE_W-1:0]    cfg_data  = '0;

  // score model state
  logic [GENE_W-1:0]        sel_a, sel_b, sel_c;
  logic signed [EXPR_W-1:0] held_a, held_b, held_c;
  int unsigned              bin_credit [2][ORDER_COUNT];
  int unsigned              class_count [2];

  out_item_t  pending_scores [$];
  table_row_t stim_table [$];

  int   items_sent   = 0;
  int   results_seen = 0;
  int   mismatches   = 0;
  logic calm         = 1'b0;
  logic hold_done    = 1'b0;

  triple_rank_order_score uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic void clear_counts();
    for (int c = 0; c < 2; c++) begin
      class_count[c] = 0;
      for (int i = 0; i < ORDER_COUNT; i++) bin_credit[c][i] = 0;
    end
  endfunction

  // credit the orderings that hold, in sixths, unless the set is full
  function automatic void close_sample(input logic cls);
    logic [ORDER_COUNT-1:0] holds;
    int unsigned            weight;
    holds[0] = (held_a <= held_b) && (held_b <= held_c);
    holds[1] = (held_a <= held_c) && (held_c <= held_b);
    holds[2] = (held_b <= held_a) && (held_a <= held_c);
    holds[3] = (held_b <= held_c) && (held_c <= held_a);
    holds[4] = (held_c <= held_a) && (held_a <= held_b);
    holds[5] = (held_c <= held_b) && (held_b <= held_a);
    if (class_count[0] + class_count[1] < MAX_SAMPLES) begin
      weight = (holds == '0) ? 1 : ORDER_COUNT / $countones(holds);
      class_count[cls]++;
      for (int i = 0; i < ORDER_COUNT; i++)
        if (holds[i]) bin_credit[cls][i] += weight;
    end
  endfunction

  // one element in; returns 1 with the set score when the set ends
  function automatic logic score_element(input in_item_t it, output out_item_t res);
    longint unsigned n0, n1, num, den, q, x, y;
    res = '0;
    if (it.gene_index == sel_a) held_a = it.expr_value;
    if (it.gene_index == sel_b) held_b = it.expr_value;
    if (it.gene_index == sel_c) held_c = it.expr_value;
    if (it.end_of_sample || it.end_of_set) close_sample(it.class_label);
    if (!it.end_of_set) return 1'b0;
    n0 = 64'(class_count[0]);
    n1 = 64'(class_count[1]);
    if (n0 == 0 || n1 == 0) begin
      res.empty_class = 1'b1;
    end else begin
      num = 0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        x = 64'(bin_credit[0][i]);
        y = 64'(bin_credit[1][i]);
        x = x * n1;
        y = y * n0;
        num += (x >= y) ? (x - y) : (y - x);
      end
      den = ORDER_COUNT * n0 * n1;
      q = (num * 131072 + den) / (2 * den);
      if (q > 131072) q = 131072;
      res.score = q[SCORE_W-1:0];
    end
    clear_counts();
    return 1'b1;
  endfunction

  // ------------------------------------------------------------ stimulus
  function automatic void add_row(input logic [GENE_W-1:0] gene,
                                  input logic signed [EXPR_W-1:0] value,
                                  input logic cls, input logic eos, input logic eset,
                                  input logic typed, input int unsigned score,
                                  input logic empty);
    table_row_t row;
    row.item.gene_index    = gene;
    row.item.expr_value    = value;
    row.item.class_label   = cls;
    row.item.end_of_sample = eos;
    row.item.end_of_set    = eset;
    row.typed              = typed;
    row.want.score         = score[SCORE_W-1:0];
    row.want.empty_class   = empty;
    stim_table.push_back(row);
  endfunction

  function automatic logic signed [EXPR_W-1:0] pick_value(input val_mode_t mode);
    logic signed [EXPR_W-1:0] v;
    case (mode)
      VAL_NARROW: begin
        v = $urandom_range(0, 3);
        v = v - 2;
      end
      VAL_WIDE: v = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7FFF_FFFF;
          2:       v = '0;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  // mostly one of the selected genes, sometimes anything
  function automatic logic [GENE_W-1:0] pick_gene();
    case ($urandom_range(0, 9))
      0, 1, 2: return sel_a;
      3, 4, 5: return sel_b;
      6, 7:    return sel_c;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // offer one item, wait for it to be taken, then predict
  task automatic send_element(input in_item_t it, input logic typed, input out_item_t want);
    logic      taken;
    out_item_t res;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      taken = !in_full;
      @(posedge clk);
    end while (!taken);
    if (score_element(it, res)) pending_scores.push_back(typed ? want : res);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GENE_W-1:0] data);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    case (idx)
      CFG_GENE_A: sel_a = data;
      CFG_GENE_B: sel_b = data;
      CFG_GENE_C: sel_c = data;
      default: ;
    endcase
  endtask

  // well-formed set: samples of one class each, set end on the last element
  task automatic send_random_set();
    int        n_samples, n_elems;
    logic      cls;
    val_mode_t mode;
    in_item_t  it;
    n_samples = $urandom_range(1, 8);
    mode      = val_mode_t'($urandom_range(0, 2));
    for (int s = 0; s < n_samples; s++) begin
      cls     = 1'($urandom_range(0, 1));
      n_elems = $urandom_range(1, 6);
      for (int e = 0; e < n_elems; e++) begin
        it.gene_index    = pick_gene();
        it.expr_value    = pick_value(mode);
        it.class_label   = cls;
        it.end_of_sample = (e == n_elems - 1);
        it.end_of_set    = 1'b0;
        if (s == n_samples - 1 && e == n_elems - 1) begin
          it.end_of_set    = 1'b1;
          it.end_of_sample = 1'($urandom_range(0, 1));
        end
        send_element(it, 1'b0, '0);
      end
    end
  endtask

  // unstructured items, any flags
  task automatic send_noise();
    in_item_t it;
    repeat ($urandom_range(1, 6)) begin
      it.gene_index    = $urandom_range(0, 1) ? pick_gene() : 16'($urandom_range(0, 65535));
      it.expr_value    = $urandom;
      it.class_label   = 1'($urandom_range(0, 1));
      it.end_of_sample = 1'($urandom_range(0, 1));
      it.end_of_set    = ($urandom_range(0, 7) == 0);
      send_element(it, 1'b0, '0);
    end
  endtask

  // stop offering, let every result come back and the pipeline empty
  task automatic settle();
    in_push <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [GENE_W-1:0] ga, input logic [GENE_W-1:0] gb,
                           input logic [GENE_W-1:0] gc, input int budget,
                           input phase_kind_t kind, input logic poke_unused);
    int start;
    write_reg(CFG_GENE_A, ga);
    write_reg(CFG_GENE_B, gb);
    write_reg(CFG_GENE_C, gc);
    if (poke_unused) write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    start = items_sent;
    while (items_sent - start < budget) begin
      if (kind == PH_CLOSING && items_sent - start >= budget - 200) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_random_set();
    end
    settle();
  endtask

  // ------------------------------------------------------------ main flow
  initial begin : stimulus
    sel_a  = 16'd0;
    sel_b  = 16'd1;
    sel_c  = 16'd2;
    held_a = '0;
    held_b = '0;
    held_c = '0;
    clear_counts();

    // gene, value, class, eos, eset, typed, score, empty_class
    // right after reset: set end alone, all held values zero, one class only
    add_row(16'd100, 0, 1'b0, 1'b0, 1'b1, 1'b1, 0, 1'b1);
    // ascending in class 0, descending in class 1: full separation
    add_row(16'd0, 1, 1'b0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd1, 2, 1'b0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd2, 3, 1'b0, 1'b1, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd2, 1, 1'b1, 1'b0, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd1, 2, 1'b1, 1'b0, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd0, 3, 1'b1, 1'b1, 1'b1, 1'b1, 131072, 1'b0);
    // value extremes; class 1 sample reuses the held values
    add_row(16'd0, 32'sh8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd1, 32'sh7FFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd2, 0, 1'b0, 1'b1, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'hFFFF, 32'sh5A5A_A5A5, 1'b1, 1'b1, 1'b1, 1'b1, 0, 1'b0);
    // a tied pair, then all three tied
    add_row(16'd0, 5, 1'b0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd1, 5, 1'b0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd2, 7, 1'b0, 1'b1, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd0, -1, 1'b1, 1'b0, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd1, -1, 1'b1, 1'b0, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd2, -1, 1'b1, 1'b1, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd2, 4, 1'b1, 1'b1, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd3, 0, 1'b0, 1'b0, 1'b1, 1'b0, 0, 1'b0);
    // only class 1 in the set
    add_row(16'd0, 9, 1'b1, 1'b1, 1'b0, 1'b0, 0, 1'b0);
    add_row(16'd1, 4, 1'b1, 1'b0, 1'b1, 1'b1, 0, 1'b1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) send_element(stim_table[i].item, stim_table[i].typed,
                                         stim_table[i].want);
    settle();

    run_phase(16'hFFFF, 16'h0000, 16'h8000, 500, PH_RANDOM, 1'b0);
    run_phase(16'd7, 16'd7, 16'd9, 500, PH_RANDOM, 1'b1);
    run_phase(16'hA5A5, 16'hA5A5, 16'hA5A5, 350, PH_RANDOM, 1'b0);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 600, PH_CLOSING, 1'b0);

    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // -------------------------------------------------------- result side
  initial begin : result_side
    out_item_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= 15) begin
        // long hold-off so the block fills and stalls its input
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(negedge clk);
      if (!out_empty) begin
        results_seen++;
        if (pending_scores.size() == 0) begin
          if (mismatches < 10)
            $display("ERROR: unexpected result score=%0d empty_class=%0b",
                     out_item.score, out_item.empty_class);
          mismatches++;
        end else begin
          want = pending_scores.pop_front();
          if (out_item.score !== want.score || out_item.empty_class !== want.empty_class) begin
            if (mismatches < 10)
              $display("ERROR: result %0d: expected score=%0d empty=%0b, got %0d %0b",
                       results_seen, want.score, want.empty_class,
                       out_item.score, out_item.empty_class);
            mismatches++;
          end
        end
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/trs_pkg.sv
rtl/trs_front.sv
rtl/trs_snapq.sv
rtl/trs_back.sv
rtl/triple_rank_order_score.sv
rtl/trs_checker.sv
tb/sv/triple_rank_order_score_tb.sv
